### hw/rtl/mcpd_pkg.sv
// shared types and constants for the motor command packet deframer
package mcpd_pkg;

    localparam int MAX_WORDS         = 8;
    localparam int WORD_W            = 32;
    localparam int DEF_MOTOR_COUNT   = 8;
    localparam int CFG_IDX_W         = 2;
    localparam logic [7:0] DEF_HEADER_FIRST  = 8'hAA;
    localparam logic [7:0] DEF_HEADER_SECOND = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR1 = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } t_hdr;

    typedef struct packed {
        logic                                valid;
        logic                                bank;
        logic [MAX_WORDS-1:0][WORD_W-1:0]    words;
    } t_res;

    typedef struct packed {
        t_phase     phase;
        logic [4:0] count;
    } t_stat;

endpackage

### hw/rtl/mcpd_parse.sv
// header hunt, payload gathering and bank toggle for one byte per cycle while i_proc is high
module mcpd_parse #(
    parameter int MOTOR_COUNT = mcpd_pkg::DEF_MOTOR_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_proc,
    input  logic             i_op,
    input  logic [7:0]       i_byte,
    input  mcpd_pkg::t_hdr   i_hdr,
    output mcpd_pkg::t_res   o_res,
    output mcpd_pkg::t_stat  o_stat
);
    import mcpd_pkg::*;

    localparam logic [4:0] LAST = 5'(MOTOR_COUNT * 4 - 1);

    t_phase                          r_phase, n_phase;
    logic [4:0]                      r_count, n_count;
    logic                            r_bank, n_bank;
    logic [MAX_WORDS-1:0][WORD_W-1:0] r_words, n_words;
    logic                            res_valid;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_bank    = r_bank;
        n_words   = r_words;
        res_valid = 1'b0;
        if (i_proc) begin
            if (i_op == OP_FLUSH) begin
                n_phase = PH_HUNT;
                n_count = '0;
            end else begin
                case (r_phase)
                    PH_HDR1: begin
                        if (i_byte == i_hdr.second) begin
                            n_phase = PH_DATA;
                            n_count = '0;
                        end else if (i_byte == i_hdr.first) begin
                            n_phase = PH_HDR1;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_DATA: begin
                        for (int k = 0; k < MAX_WORDS; k++) begin
                            for (int l = 0; l < 4; l++) begin
                                if (k < MOTOR_COUNT && r_count == 5'(k * 4 + l)) begin
                                    n_words[k][l*8 +: 8] = i_byte;
                                end
                            end
                        end
                        if (r_count >= LAST) begin
                            n_bank    = ~r_bank;
                            res_valid = 1'b1;
                            n_phase   = PH_HUNT;
                            n_count   = '0;
                        end else begin
                            n_count = r_count + 5'd1;
                        end
                    end
                    default: begin
                        n_phase = (i_byte == i_hdr.first) ? PH_HDR1 : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.valid = res_valid;
        o_res.bank  = n_bank;
        for (int k = 0; k < MAX_WORDS; k++) begin
            o_res.words[k] = (k < MOTOR_COUNT) ? n_words[k] : '0;
        end
        o_stat.phase = r_phase;
        o_stat.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

endmodule

### hw/rtl/mcpd_out.sv
// result register on the master side of the stream
module mcpd_out (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  mcpd_pkg::t_res                                     i_res,
    input  logic                                               i_m_tready,
    output logic                                               o_m_tvalid,
    output logic [mcpd_pkg::MAX_WORDS*mcpd_pkg::WORD_W-1:0]    o_m_tdata,
    output logic                                               o_m_tuser
);
    import mcpd_pkg::*;

    logic                            r_valid;
    logic [MAX_WORDS*WORD_W-1:0]     r_data;
    logic                            r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_data <= i_res.words;
            r_bank <= i_res.bank;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_bank;

endmodule

### hw/rtl/motor_command_packet_deframer_unit.sv
// Motor command packet deframer: one received byte or flush event per item,
// one packet of MOTOR_COUNT little-endian 32-bit command words per result.
// An item is taken every clock while the output side keeps up; it sits in the
// input register, is parsed in a single pass against the header and payload
// state, and a completed packet lands in the result register in the cycle
// after its last byte is parsed. The input register holds one more item while
// a result waits, so the rate is one item per cycle while the output keeps up.
// Header bytes are written over the cfg channel (index 0 first byte, index 1
// second byte); unknown indexes are ignored. No clearing pass after reset.
module motor_command_packet_deframer_unit #(
    parameter int MOTOR_COUNT = mcpd_pkg::DEF_MOTOR_COUNT
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    // slave side
    input  logic                                               i_s_tvalid,
    output logic                                               o_s_tready,
    input  logic [7:0]                                         i_s_tdata,  // rx_byte
    input  logic                                               i_s_tuser,  // op
    // master side
    output logic                                               o_m_tvalid,
    input  logic                                               i_m_tready,
    // command_0 .. command_7, 32 bits each
    output logic [mcpd_pkg::MAX_WORDS*mcpd_pkg::WORD_W-1:0]    o_m_tdata,
    output logic                                               o_m_tuser,  // bank
    // config write
    input  logic                                               i_cfg_valid,
    output logic                                               o_cfg_ready,
    input  logic [mcpd_pkg::CFG_IDX_W-1:0]                     i_cfg_index,
    input  logic [7:0]                                         i_cfg_data
);
    import mcpd_pkg::*;

    localparam logic [4:0] LAST = 5'(MOTOR_COUNT * 4 - 1);

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    t_hdr       r_hdr;
    logic       proc;
    t_res       res;
    t_stat      stat;

    assign proc        = r_in_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready  = !r_in_valid || proc;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_op   <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.first  <= DEF_HEADER_FIRST;
            r_hdr.second <= DEF_HEADER_SECOND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr.first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr.second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcpd_parse #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_proc (proc),
        .i_op   (r_in_op),
        .i_byte (r_in_byte),
        .i_hdr  (r_hdr),
        .o_res  (res),
        .o_stat (stat)
    );

    mcpd_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (res),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    // flush item always returns to hunt
    a_flush_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_op == OP_FLUSH |=> stat.phase == PH_HUNT && stat.count == 5'd0)
        else $error("flush did not return to hunt");

    // a packet completes only on the last payload byte
    a_res_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> proc && r_in_op == OP_DATA && stat.phase == PH_DATA
                      && stat.count == LAST)
        else $error("packet completed early");

    // payload count never passes the packet length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= LAST)
        else $error("payload count out of range");

    // each packet flips the bank
    a_bank_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |=> o_m_tvalid && o_m_tuser == !$past(u_parse.r_bank))
        else $error("bank not toggled");

endmodule
